// ===== design/rkt_pkg.sv =====
package rkt_pkg;

  // Field widths of the transaction payloads.
  localparam int KEY_W  = 64;
  localparam int SLOT_W = 8;
  localparam int CAP_W  = 9;

  // Register file layout: one 32-bit register per 4-byte word.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic [0:0] REG_CAPACITY = 1'b0;

  // Reset value of the capacity register.
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Operation codes.
  localparam logic [0:0] OP_TOUCH = 1'b0;
  localparam logic [0:0] OP_QUERY = 1'b1;

  typedef struct packed {
    logic [0:0]        opcode;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] random_slot;
  } in_item_t;

  typedef struct packed {
    logic             present;
    logic             stored;
    logic             evicted_valid;
    logic [KEY_W-1:0] evicted_key;
    logic             slot_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_EVICT,
    ST_RESULT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic append_wr;
    logic evict_rd;
    logic evict_wr;
    logic set_err;
    logic out_load;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic is_query;
    logic hit;
    logic full;
    logic slot_ok;
    logic out_free;
  } ctl_stat_t;

endpackage

// ===== design/random_eviction_key_table_core.sv =====
// Random-replacement key table. Each input transaction touches or queries a
// 64-bit key and yields exactly one result. Keys live in a single memory of
// CAPACITY entries that is searched linearly, one entry per cycle through its
// one read port, stopping early on a match. A transaction passes from the
// scan state through the decide state, and the evict state when a key is
// evicted, to the result state. When the table holds at least
// capacity_in_use keys (clamped to 1..CAPACITY), a touch of a new key
// replaces the entry at random_slot, supplied from outside, and returns the
// old key; a slot at or above that capacity gives a slot error instead. The
// memory is not cleared at reset; only entries below the fill count are
// ever read. A finished result waits in an output register while the next
// transaction is accepted. capacity_in_use sits at APB byte address 0. The
// user must write it only while the block is idle; the block has no check.
module random_eviction_key_table_core
  import rkt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic [CAP_W-1:0] capacity_in_use;
  logic [0:0]       reg_idx;
  ctl_cmd_t         cmd;
  ctl_stat_t        stat;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2:2];

  // Configuration register write.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_in_use <= CAP_RESET;
    end else if (psel && penable && pwrite && (reg_idx == REG_CAPACITY)) begin
      capacity_in_use <= pwdata[CAP_W-1:0];
    end
  end

  // Register read decode.
  always_comb begin
    unique case (reg_idx)
      REG_CAPACITY: prdata = APB_DATA_W'(capacity_in_use);
      default:      prdata = '0;
    endcase
  end

  rkt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rkt_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .in_data         (in_data),
    .capacity_in_use (capacity_in_use),
    .cmd             (cmd),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data)
  );

endmodule

// ===== design/rkt_ram.sv =====
module rkt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Simple dual-port array with a registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/rkt_ctrl.sv =====
module rkt_ctrl
  import rkt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ctl_stat_t stat,
  output ctl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_query || stat.hit) begin
          state_next = ST_RESULT;
        end else if (!stat.full) begin
          cmd.append_wr = 1'b1;
          state_next    = ST_RESULT;
        end else if (stat.slot_ok) begin
          cmd.evict_rd = 1'b1;
          state_next   = ST_EVICT;
        end else begin
          cmd.set_err = 1'b1;
          state_next  = ST_RESULT;
        end
      end
      ST_EVICT: begin
        // The victim key is on the read port now; overwrite its slot.
        cmd.evict_wr = 1'b1;
        state_next   = ST_RESULT;
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/rkt_dpath.sv =====
module rkt_dpath
  import rkt_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_data,
  input  logic [CAP_W-1:0] capacity_in_use,
  input  ctl_cmd_t         cmd,
  output ctl_stat_t        stat,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  in_item_t         item;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] cap_eff;
  logic             cmp_vld;
  logic             hit;
  logic             scan_issue;
  logic             cur_match;
  logic             res_stored;
  logic             res_evicted;
  logic             res_err;
  logic [KEY_W-1:0] ev_key;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [KEY_W-1:0] ram_rdata;

  // Clamp the programmed capacity to the range the table supports.
  always_comb begin
    if (capacity_in_use == '0) begin
      cap_eff = CNT_W'(1);
    end else if (CMP_W'(capacity_in_use) > CMP_W'(CAPACITY)) begin
      cap_eff = CNT_W'(CAPACITY);
    end else begin
      cap_eff = CNT_W'(capacity_in_use);
    end
  end

  // Scan issues one read per cycle over the filled entries until a match.
  assign scan_issue = cmd.scan && !hit && (scan_idx < fill_count);
  assign cur_match  = cmp_vld && (ram_rdata == item.key);

  // Memory port steering.
  assign ram_re    = scan_issue || cmd.evict_rd;
  assign ram_raddr = cmd.evict_rd ? AW'(item.random_slot) : scan_idx[AW-1:0];
  assign ram_we    = cmd.append_wr || cmd.evict_wr;
  assign ram_waddr = cmd.evict_wr ? AW'(item.random_slot) : fill_count[AW-1:0];

  rkt_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item.key),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Captured transaction and victim key.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.evict_wr) begin
      ev_key <= ram_rdata;
    end
  end

  // Scan control, fill count and result flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count  <= '0;
      scan_idx    <= '0;
      cmp_vld     <= 1'b0;
      hit         <= 1'b0;
      res_stored  <= 1'b0;
      res_evicted <= 1'b0;
      res_err     <= 1'b0;
    end else if (cmd.load) begin
      scan_idx    <= '0;
      cmp_vld     <= 1'b0;
      hit         <= 1'b0;
      res_stored  <= 1'b0;
      res_evicted <= 1'b0;
      res_err     <= 1'b0;
    end else begin
      cmp_vld <= scan_issue;
      if (scan_issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
      if (cur_match) begin
        hit <= 1'b1;
      end
      if (cmd.append_wr) begin
        fill_count <= fill_count + 1'b1;
        res_stored <= 1'b1;
      end
      if (cmd.evict_wr) begin
        res_stored  <= 1'b1;
        res_evicted <= 1'b1;
      end
      if (cmd.set_err) begin
        res_err <= 1'b1;
      end
    end
  end

  // Output register: holds one finished transaction until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.present       <= hit;
      out_data.stored        <= res_stored;
      out_data.evicted_valid <= res_evicted;
      out_data.evicted_key   <= res_evicted ? ev_key : '0;
      out_data.slot_error    <= res_err;
    end
  end

  // Status toward the controller.
  always_comb begin
    stat.scan_done = !cmp_vld && (hit || (scan_idx >= fill_count));
    stat.is_query  = (item.opcode == OP_QUERY);
    stat.hit       = hit;
    stat.full      = (fill_count >= cap_eff);
    stat.slot_ok   = (CMP_W'(item.random_slot) < CMP_W'(cap_eff));
    stat.out_free  = !out_valid || out_ready;
  end

  // The fill count never passes the table size.
  assert property (@(posedge clk) disable iff (rst)
    CMP_W'(fill_count) <= CMP_W'(CAPACITY))
    else $error("fill count exceeds table size");

  // An append only happens while there is room below the capacity.
  assert property (@(posedge clk) disable iff (rst)
    cmd.append_wr |-> (fill_count < cap_eff))
    else $error("append into a full table");

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // A reported eviction always comes with a stored key and no slot error.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.evicted_valid) |-> (out_data.stored && !out_data.slot_error))
    else $error("inconsistent eviction result");

endmodule
